/* src/windowed_energy_accumulator_assert.svh */
// assertion macros shared by the checker of the windowed energy accumulator
`ifndef WINDOWED_ENERGY_ACCUMULATOR_ASSERT_SVH
`define WINDOWED_ENERGY_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WEA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define WEA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/wea_pkg.sv */
// shared types, widths and helpers of the windowed energy accumulator
package wea_pkg;

    localparam int IN_DATA_W   = 192;
    localparam int IN_USER_W   = 3;
    localparam int OUT_DATA_W  = 576;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    localparam int unsigned US_PER_SEC = 1000000;
    localparam int DIVIDEND_W    = 64;
    localparam int DIV_STEP_BITS = 4;
    localparam int REM_W         = $clog2(US_PER_SEC);

    typedef struct packed {
        logic [63:0] now_us;
        logic [31:0] capture_time_us;
        logic [31:0] gate_time_us;
        logic [31:0] infer_time_us;
        logic [31:0] emit_time_us;
        logic        has_reference;
        logic        did_infer;
        logic        forced_compare;
    } t_in;

    typedef struct packed {
        logic [31:0] report_window_number;
        logic [31:0] frame_count;
        logic [31:0] ref_ready_count;
        logic [31:0] infer_count;
        logic [31:0] skip_count;
        logic [31:0] forced_count;
        logic [63:0] busy_total_us;
        logic [63:0] infer_total_us;
        logic [63:0] window_span_us;
        logic [63:0] idle_total_us;
        logic [63:0] saved_compute_us;
        logic [63:0] energy_microjoules;
    } t_rpt;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

endpackage

/* src/windowed_energy_accumulator.sv */
// top level: window accumulators, shared multiplier sequencer and report register
//
//  channel   | direction | contents
//  s_axis    | in        | tdata: now, capture, gate, infer, emit times; tuser: flags
//  m_axis    | out       | tdata: closed window report
//  apb       | in/out    | eight configuration registers at 4*i
//
// an item that leaves its window open passes through ST_ACC and ST_CHK before the next input
// an item that closes a window also runs five energy terms, each three passes of the
// 32x32 multiplier and one run of the divider
// reset is synchronous; it loads default configuration, clears window state and drops the report
// a pending report does not block new input, but a second close waits for it
module windowed_energy_accumulator import wea_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // now_us[63:0], capture_time_us[95:64], gate_time_us[127:96],
    // infer_time_us[159:128], emit_time_us[191:160]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // has_reference[0], did_infer[1], forced_compare[2]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // report_window_number, frame_count, ref_ready_count, infer_count, skip_count,
    // forced_count (32 each), busy_total_us, infer_total_us, window_span_us,
    // idle_total_us, saved_compute_us, energy_microjoules (64 each)
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [2:0] REG_WIN_LEN  = 3'd0;
    localparam logic [2:0] REG_SUPPLY   = 3'd1;
    localparam logic [2:0] REG_CPU_BUSY = 3'd2;
    localparam logic [2:0] REG_CPU_SLP  = 3'd3;
    localparam logic [2:0] REG_CAMERA   = 3'd4;
    localparam logic [2:0] REG_PSRAM    = 3'd5;
    localparam logic [2:0] REG_BASELINE = 3'd6;
    localparam logic [2:0] REG_REF_INF  = 3'd7;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ACC  = 4'd1;
    localparam logic [3:0] ST_CHK  = 4'd2;
    localparam logic [3:0] ST_IDL  = 4'd3;
    localparam logic [3:0] ST_SAV  = 4'd4;
    localparam logic [3:0] ST_MA   = 4'd5;
    localparam logic [3:0] ST_LO   = 4'd6;
    localparam logic [3:0] ST_HI   = 4'd7;
    localparam logic [3:0] ST_DST  = 4'd8;
    localparam logic [3:0] ST_DIV  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    localparam logic [2:0] TERM_BUSY  = 3'd0;
    localparam logic [2:0] TERM_SLEEP = 3'd1;
    localparam logic [2:0] TERM_CAM   = 3'd2;
    localparam logic [2:0] TERM_PSRAM = 3'd3;
    localparam logic [2:0] TERM_BASE  = 3'd4;

    // configuration
    logic [31:0] r_win_len;
    logic [15:0] r_mv;
    logic [15:0] r_ma_busy;
    logic [15:0] r_ma_sleep;
    logic [15:0] r_ma_cam;
    logic [15:0] r_ma_psram;
    logic [15:0] r_ma_base;
    logic [31:0] r_ref_inf;

    // window state
    logic        r_open;
    logic [63:0] r_start;
    logic [31:0] r_win_num;
    logic [31:0] r_frames;
    logic [31:0] r_refrdy;
    logic [31:0] r_inf_cnt;
    logic [31:0] r_skip;
    logic [31:0] r_forced;
    logic [63:0] r_busy;
    logic [63:0] r_gate;
    logic [63:0] r_infer;

    // sequencer and work registers
    logic [3:0]  r_state;
    logic [3:0]  n_state;
    t_in         r_in;
    logic [63:0] r_span;
    logic [63:0] r_idle;
    logic [63:0] r_saved;
    logic [63:0] r_energy;
    logic [63:0] r_mul;
    logic [31:0] r_mvma;
    logic [63:0] r_plo;
    logic [2:0]  r_term;
    logic        r_ovld;
    t_rpt        r_out;

    logic        in_acc;
    logic        cfg_wr;
    logic        out_free;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [15:0] ma_sel;
    logic [63:0] dur_sel;
    logic [63:0] span;
    logic        close;
    logic [33:0] busy_item;
    logic [31:0] b_frames;
    logic [31:0] b_refrdy;
    logic [31:0] b_inf_cnt;
    logic [31:0] b_skip;
    logic [31:0] b_forced;
    logic [63:0] b_busy;
    logic [63:0] b_gate;
    logic [63:0] b_infer;
    logic        div_start;
    logic [63:0] div_dividend;
    logic        div_done;
    logic [63:0] div_quot;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign pready        = 1'b1;
    assign out_free      = !r_ovld || m_axis_tready;

    // a closed window starts the next one empty, so a closed state reads as zero
    assign b_frames  = r_open ? r_frames  : '0;
    assign b_refrdy  = r_open ? r_refrdy  : '0;
    assign b_inf_cnt = r_open ? r_inf_cnt : '0;
    assign b_skip    = r_open ? r_skip    : '0;
    assign b_forced  = r_open ? r_forced  : '0;
    assign b_busy    = r_open ? r_busy    : '0;
    assign b_gate    = r_open ? r_gate    : '0;
    assign b_infer   = r_open ? r_infer   : '0;
    assign busy_item = {2'b00, r_in.capture_time_us} + {2'b00, r_in.gate_time_us}
                     + {2'b00, r_in.infer_time_us} + {2'b00, r_in.emit_time_us};

    assign span  = (r_in.now_us >= r_start) ? (r_in.now_us - r_start) : '0;
    assign close = (span >= {32'd0, r_win_len});

    always_comb begin
        case (r_term)
            TERM_BUSY: begin
                ma_sel  = r_ma_busy;
                dur_sel = r_busy;
            end
            TERM_SLEEP: begin
                ma_sel  = r_ma_sleep;
                dur_sel = r_idle;
            end
            TERM_CAM: begin
                ma_sel  = r_ma_cam;
                dur_sel = r_span;
            end
            TERM_PSRAM: begin
                ma_sel  = r_ma_psram;
                dur_sel = r_infer;
            end
            default: begin
                ma_sel  = r_ma_base;
                dur_sel = r_span;
            end
        endcase
    end

    // shared multiplier operands; the product mod 2^64 needs only the low half of mvma * dur_hi
    always_comb begin
        case (r_state)
            ST_IDL: begin
                mul_a = r_skip;
                mul_b = r_ref_inf;
            end
            ST_MA: begin
                mul_a = {16'd0, r_mv};
                mul_b = {16'd0, ma_sel};
            end
            ST_LO: begin
                mul_a = r_mul[31:0];
                mul_b = dur_sel[31:0];
            end
            ST_HI: begin
                mul_a = r_mvma;
                mul_b = dur_sel[63:32];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mul <= {32'd0, mul_a} * {32'd0, mul_b};
    end

    assign div_start    = (r_state == ST_DST);
    assign div_dividend = r_plo + {r_mul[31:0], 32'd0};

    wea_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (r_win_len != '0)) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC:  n_state = ST_CHK;
            ST_CHK:  n_state = close ? ST_IDL : ST_IDLE;
            ST_IDL:  n_state = ST_SAV;
            ST_SAV:  n_state = ST_MA;
            ST_MA:   n_state = ST_LO;
            ST_LO:   n_state = ST_HI;
            ST_HI:   n_state = ST_DST;
            ST_DST:  n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = (r_term == TERM_BASE) ? ST_OUT : ST_MA;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len  <= 32'd1000000;
            r_mv       <= 16'd3300;
            r_ma_busy  <= '0;
            r_ma_sleep <= '0;
            r_ma_cam   <= '0;
            r_ma_psram <= '0;
            r_ma_base  <= '0;
            r_ref_inf  <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_WIN_LEN:  r_win_len  <= pwdata;
                REG_SUPPLY:   r_mv       <= pwdata[15:0];
                REG_CPU_BUSY: r_ma_busy  <= pwdata[15:0];
                REG_CPU_SLP:  r_ma_sleep <= pwdata[15:0];
                REG_CAMERA:   r_ma_cam   <= pwdata[15:0];
                REG_PSRAM:    r_ma_psram <= pwdata[15:0];
                REG_BASELINE: r_ma_base  <= pwdata[15:0];
                REG_REF_INF:  r_ref_inf  <= pwdata;
                default:      r_ref_inf  <= r_ref_inf;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_WIN_LEN:  prdata = r_win_len;
            REG_SUPPLY:   prdata = {16'd0, r_mv};
            REG_CPU_BUSY: prdata = {16'd0, r_ma_busy};
            REG_CPU_SLP:  prdata = {16'd0, r_ma_sleep};
            REG_CAMERA:   prdata = {16'd0, r_ma_cam};
            REG_PSRAM:    prdata = {16'd0, r_ma_psram};
            REG_BASELINE: prdata = {16'd0, r_ma_base};
            REG_REF_INF:  prdata = r_ref_inf;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.now_us          <= s_axis_tdata[63:0];
            r_in.capture_time_us <= s_axis_tdata[95:64];
            r_in.gate_time_us    <= s_axis_tdata[127:96];
            r_in.infer_time_us   <= s_axis_tdata[159:128];
            r_in.emit_time_us    <= s_axis_tdata[191:160];
            r_in.has_reference   <= s_axis_tuser[0];
            r_in.did_infer       <= s_axis_tuser[1];
            r_in.forced_compare  <= s_axis_tuser[2];
        end
    end

    // sequencer, window state and report register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_open    <= 1'b0;
            r_start   <= '0;
            r_win_num <= '0;
            r_frames  <= '0;
            r_refrdy  <= '0;
            r_inf_cnt <= '0;
            r_skip    <= '0;
            r_forced  <= '0;
            r_busy    <= '0;
            r_gate    <= '0;
            r_infer   <= '0;
            r_term    <= '0;
            r_ovld    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovld && m_axis_tready) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                ST_ACC: begin
                    r_open <= 1'b1;
                    if (!r_open) begin
                        r_start <= r_in.now_us;
                    end
                    r_frames  <= sat_inc32(b_frames);
                    r_refrdy  <= r_in.has_reference ? sat_inc32(b_refrdy) : b_refrdy;
                    r_inf_cnt <= r_in.did_infer ? sat_inc32(b_inf_cnt) : b_inf_cnt;
                    r_skip    <= (!r_in.did_infer && r_in.has_reference)
                               ? sat_inc32(b_skip) : b_skip;
                    r_forced  <= r_in.forced_compare ? sat_inc32(b_forced) : b_forced;
                    r_gate    <= sat_add64(b_gate, {32'd0, r_in.gate_time_us});
                    r_infer   <= sat_add64(b_infer, {32'd0, r_in.infer_time_us});
                    r_busy    <= sat_add64(b_busy, {30'd0, busy_item});
                end
                ST_CHK: begin
                    r_span <= span;
                end
                ST_IDL: begin
                    r_idle <= (r_busy < r_span) ? (r_span - r_busy) : '0;
                end
                ST_SAV: begin
                    r_saved  <= (r_mul > r_gate) ? (r_mul - r_gate) : '0;
                    r_term   <= TERM_BUSY;
                    r_energy <= '0;
                end
                ST_LO: begin
                    r_mvma <= r_mul[31:0];
                end
                ST_HI: begin
                    r_plo <= r_mul;
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_energy <= sat_add64(r_energy, div_quot);
                        r_term   <= r_term + 3'd1;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_ovld                     <= 1'b1;
                        r_out.report_window_number <= r_win_num;
                        r_out.frame_count          <= r_frames;
                        r_out.ref_ready_count      <= r_refrdy;
                        r_out.infer_count          <= r_inf_cnt;
                        r_out.skip_count           <= r_skip;
                        r_out.forced_count         <= r_forced;
                        r_out.busy_total_us        <= r_busy;
                        r_out.infer_total_us       <= r_infer;
                        r_out.window_span_us       <= r_span;
                        r_out.idle_total_us        <= r_idle;
                        r_out.saved_compute_us     <= r_saved;
                        r_out.energy_microjoules   <= r_energy;
                        r_win_num <= sat_inc32(r_win_num);
                        r_start   <= r_in.now_us;
                        r_frames  <= '0;
                        r_refrdy  <= '0;
                        r_inf_cnt <= '0;
                        r_skip    <= '0;
                        r_forced  <= '0;
                        r_busy    <= '0;
                        r_gate    <= '0;
                        r_infer   <= '0;
                    end
                end
                default: begin
                    r_term <= r_term;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {r_out.energy_microjoules, r_out.saved_compute_us,
                            r_out.idle_total_us, r_out.window_span_us,
                            r_out.infer_total_us, r_out.busy_total_us,
                            r_out.forced_count, r_out.skip_count, r_out.infer_count,
                            r_out.ref_ready_count, r_out.frame_count,
                            r_out.report_window_number};

endmodule

/* src/wea_div.sv */
// iterative divider of a 64-bit value by one million, four quotient bits per cycle
module wea_div import wea_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quot
);

    localparam int STEPS = DIVIDEND_W / DIV_STEP_BITS;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [REM_W:0] DIV_C = (REM_W+1)'(US_PER_SEC);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_q;
    logic [REM_W-1:0]      r_rem;
    logic [DIVIDEND_W-1:0] n_q;
    logic [REM_W-1:0]      n_rem;

    // dividend shifts out of the top while quotient bits shift in at the bottom
    always_comb begin
        logic [REM_W:0] t;
        logic           ge;
        n_q   = r_q;
        n_rem = r_rem;
        for (int k = 0; k < DIV_STEP_BITS; k++) begin
            t     = {n_rem, n_q[DIVIDEND_W-1]};
            ge    = (t >= DIV_C);
            n_q   = {n_q[DIVIDEND_W-2:0], ge};
            n_rem = ge ? REM_W'(t - DIV_C) : t[REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS - 1);
                r_q    <= i_dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* src/wea_chk.sv */
// port-level checker of the windowed energy accumulator and its bind
`include "windowed_energy_accumulator_assert.svh"

module wea_chk import wea_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // a report must not vanish before it is taken
    `WEA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "report dropped while stalled")

    // the closing sample is always counted, so a report never shows an empty window
    `WEA_ASSERT_IMP(a_frames_nonzero, m_axis_tvalid, m_axis_tdata[63:32] != 32'd0, "report with zero frames")

    // skips are a subset of reference-ready frames
    `WEA_ASSERT_IMP(a_skip_le_ref, m_axis_tvalid, m_axis_tdata[159:128] <= m_axis_tdata[95:64], "skip count above ref ready count")

    // a new report appears as the sequencer returns to taking requests
    `WEA_ASSERT_IMP(a_out_rise_ready, $rose(m_axis_tvalid), s_axis_tready, "report raised while busy")

    // out of reset the block is ready and holds no report
    `WEA_ASSERT_IMP(a_reset_state, $rose(i_rst_n), s_axis_tready && !m_axis_tvalid, "bad state after reset")

endmodule

bind windowed_energy_accumulator wea_chk u_wea_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/testbench.sv */
// testbench for the windowed energy accumulator: frame sample stream in, window reports out
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wea_pkg::*;

    localparam int REG_WINDOW_LEN   = 0;
    localparam int REG_SUPPLY_MV    = 1;
    localparam int REG_CPU_BUSY_MA  = 2;
    localparam int REG_CPU_SLEEP_MA = 3;
    localparam int REG_CAMERA_MA    = 4;
    localparam int REG_PSRAM_MA     = 5;
    localparam int REG_BASELINE_MA  = 6;
    localparam int REG_REF_INFER_US = 7;

    // flag bits as they sit in tuser
    localparam bit [2:0] FL_NONE   = 3'b000;
    localparam bit [2:0] FL_REF    = 3'b001;
    localparam bit [2:0] FL_INFER  = 3'b010;
    localparam bit [2:0] FL_FORCED = 3'b100;

    localparam int RUN_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES = 200;

    class window_report_tracker;
        bit [31:0] win_len = 32'd1000000;
        bit [15:0] supply_mv = 16'd3300;
        bit [15:0] busy_ma, sleep_ma, camera_ma, psram_ma, baseline_ma;
        bit [31:0] skip_cost_us;
        bit        win_open;
        bit [63:0] win_start;
        bit [31:0] win_number, frames, ref_frames, infer_frames, skipped, forced;
        bit [63:0] busy_us, gate_us, infer_us;
        t_rpt      pending_reports[$];
        int unsigned mismatches, reports_checked, samples_noted;

        function void write_reg(int idx, bit [31:0] value);
            case (idx)
                REG_WINDOW_LEN:   win_len = value;
                REG_SUPPLY_MV:    supply_mv = value[15:0];
                REG_CPU_BUSY_MA:  busy_ma = value[15:0];
                REG_CPU_SLEEP_MA: sleep_ma = value[15:0];
                REG_CAMERA_MA:    camera_ma = value[15:0];
                REG_PSRAM_MA:     psram_ma = value[15:0];
                REG_BASELINE_MA:  baseline_ma = value[15:0];
                REG_REF_INFER_US: skip_cost_us = value;
                default: ;
            endcase
        endfunction

        function bit [31:0] bump(bit [31:0] v);
            return (&v) ? v : v + 32'd1;
        endfunction

        function bit [63:0] clamp_add(bit [63:0] a, bit [63:0] b);
            bit [63:0] s;
            s = a + b;
            return (s < a) ? {64{1'b1}} : s;
        endfunction

        // mV * mA * us wraps at 64 bits before the scale down
        function bit [63:0] joule_term(bit [15:0] ma, bit [63:0] dur_us);
            bit [63:0] p;
            p = 64'(supply_mv) * 64'(ma) * dur_us;
            return p / 64'd1000000;
        endfunction

        function void open_window(bit [63:0] t);
            win_open = 1'b1;
            win_start = t;
            frames = '0;
            ref_frames = '0;
            infer_frames = '0;
            skipped = '0;
            forced = '0;
            busy_us = '0;
            gate_us = '0;
            infer_us = '0;
        endfunction

        function void note_sample(t_in s);
            bit [63:0] busy, span, idle, avoided, energy;
            t_rpt r;
            samples_noted++;
            if (win_len == 0) return;
            if (!win_open) open_window(s.now_us);
            frames = bump(frames);
            if (s.has_reference) ref_frames = bump(ref_frames);
            if (s.did_infer) infer_frames = bump(infer_frames);
            else if (s.has_reference) skipped = bump(skipped);
            if (s.forced_compare) forced = bump(forced);
            busy = 64'(s.capture_time_us) + 64'(s.gate_time_us) + 64'(s.infer_time_us)
                 + 64'(s.emit_time_us);
            gate_us = clamp_add(gate_us, 64'(s.gate_time_us));
            infer_us = clamp_add(infer_us, 64'(s.infer_time_us));
            busy_us = clamp_add(busy_us, busy);
            span = (s.now_us >= win_start) ? s.now_us - win_start : 64'd0;
            if (span < 64'(win_len)) return;
            idle = (busy_us < span) ? span - busy_us : 64'd0;
            avoided = 64'(skipped) * 64'(skip_cost_us);
            energy = joule_term(busy_ma, busy_us);
            energy = clamp_add(energy, joule_term(sleep_ma, idle));
            energy = clamp_add(energy, joule_term(camera_ma, span));
            energy = clamp_add(energy, joule_term(psram_ma, infer_us));
            energy = clamp_add(energy, joule_term(baseline_ma, span));
            r.report_window_number = win_number;
            r.frame_count = frames;
            r.ref_ready_count = ref_frames;
            r.infer_count = infer_frames;
            r.skip_count = skipped;
            r.forced_count = forced;
            r.busy_total_us = busy_us;
            r.infer_total_us = infer_us;
            r.window_span_us = span;
            r.idle_total_us = idle;
            r.saved_compute_us = (avoided > gate_us) ? avoided - gate_us : 64'd0;
            r.energy_microjoules = energy;
            pending_reports.push_back(r);
            win_number = bump(win_number);
            open_window(s.now_us);
        endfunction

        function void check_report(logic [OUT_DATA_W-1:0] d);
            string       names [12];
            logic [63:0] got [12];
            bit   [63:0] want [12];
            t_rpt        e;
            names = '{"report_window_number", "frame_count", "ref_ready_count", "infer_count",
                      "skip_count", "forced_count", "busy_total_us", "infer_total_us",
                      "window_span_us", "idle_total_us", "saved_compute_us",
                      "energy_microjoules"};
            for (int i = 0; i < 6; i++) begin
                got[i] = {32'd0, d[32*i +: 32]};
                got[6+i] = d[192 + 64*i +: 64];
            end
            reports_checked++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report, window number %0d", got[0]);
                return;
            end
            e = pending_reports.pop_front();
            want = '{64'(e.report_window_number), 64'(e.frame_count), 64'(e.ref_ready_count),
                     64'(e.infer_count), 64'(e.skip_count), 64'(e.forced_count),
                     e.busy_total_us, e.infer_total_us, e.window_span_us, e.idle_total_us,
                     e.saved_compute_us, e.energy_microjoules};
            for (int i = 0; i < 12; i++) begin
                if (got[i] !== want[i]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("window %0d %s: expected %h, got %h",
                                 e.report_window_number, names[i], want[i], got[i]);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // now_us, capture_time_us, gate_time_us, infer_time_us, emit_time_us
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // has_reference, did_infer, forced_compare
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // window number, frame, ref, infer, skip, forced counts (32 each), busy, infer,
    // span, idle, saved compute, energy (64 each)
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    window_report_tracker tracker;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned settings_used = 0;
    int unsigned cycles = 0;
    bit [63:0]   clock_us = 64'd9000;

    windowed_energy_accumulator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_report(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("run stopped after %0d cycles", cycles);
            $display("[windowed_energy_accumulator] ERROR");
            $finish;
        end
    end

    task automatic send_sample(t_in s);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata <= {s.emit_time_us, s.infer_time_us, s.gate_time_us, s.capture_time_us,
                         s.now_us};
        s_axis_tuser <= {s.forced_compare, s.did_infer, s.has_reference};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.note_sample(s);
    endtask

    task automatic send_directed(bit [63:0] now, bit [31:0] dur, bit [2:0] flags);
        t_in s;
        s.now_us = now;
        s.capture_time_us = dur;
        s.gate_time_us = dur;
        s.infer_time_us = dur;
        s.emit_time_us = dur;
        {s.forced_compare, s.did_infer, s.has_reference} = flags;
        send_sample(s);
    endtask

    // always waits on the clock before checking, so tvalid is never lowered and raised in one step
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_reports.size() != 0);
    endtask

    task automatic settle();
        quiesce();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(int idx, bit [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(idx * 4);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.write_reg(idx, value);
    endtask

    task automatic load_settings(bit [31:0] len, bit [15:0] mv, bit [15:0] busy,
                                 bit [15:0] sleep, bit [15:0] cam, bit [15:0] psram,
                                 bit [15:0] base, bit [31:0] cost);
        settle();
        apb_write(REG_WINDOW_LEN, len);
        apb_write(REG_SUPPLY_MV, 32'(mv));
        apb_write(REG_CPU_BUSY_MA, 32'(busy));
        apb_write(REG_CPU_SLEEP_MA, 32'(sleep));
        apb_write(REG_CAMERA_MA, 32'(cam));
        apb_write(REG_PSRAM_MA, 32'(psram));
        apb_write(REG_BASELINE_MA, 32'(base));
        apb_write(REG_REF_INFER_US, cost);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        settings_used++;
    endtask

    function automatic bit [31:0] pick_duration(bit wide, int unsigned hint);
        return wide ? $urandom : $urandom_range(0, hint / 16 + 1);
    endfunction

    // mostly steadily advancing timestamps; some stale ones and some long jumps
    task automatic send_random(int count);
        t_in         s;
        int unsigned len_hint;
        bit          wide;
        for (int n = 0; n < count; n++) begin
            len_hint = (tracker.win_len > 32'd60000) ? 60000 : tracker.win_len;
            if ($urandom_range(0, 59) == 0) quiesce();
            wide = ($urandom_range(0, 5) == 0);
            s.capture_time_us = pick_duration(wide, len_hint);
            s.gate_time_us = pick_duration(wide, len_hint);
            s.infer_time_us = pick_duration(wide, len_hint);
            s.emit_time_us = pick_duration(wide, len_hint);
            {s.forced_compare, s.did_infer, s.has_reference} = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 19))
                0, 1: s.now_us = clock_us - $urandom_range(0, 500);
                2, 3: begin
                    clock_us = clock_us + (64'($urandom) << $urandom_range(0, 8));
                    s.now_us = clock_us;
                end
                default: begin
                    clock_us = clock_us + $urandom_range(0, len_hint / 3 + 2);
                    s.now_us = clock_us;
                end
            endcase
            send_sample(s);
        end
    endtask

    initial begin
        bit [63:0] rnd;
        tracker = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_settings(32'd1000, 16'd3300, 16'd120, 16'd8, 16'd60, 16'd25, 16'd40, 32'd1500);
        send_directed(64'd5000, 32'd0, FL_NONE);
        send_directed(64'd5100, 32'hFFFF_FFFF, FL_REF | FL_INFER | FL_FORCED);
        send_directed(64'd4000, 32'd3, FL_REF);
        send_directed(64'd5400, 32'd5, FL_INFER);
        send_directed(64'd5999, 32'd7, FL_REF | FL_INFER);
        // span equals the window length exactly, busy time exceeds it
        send_directed(64'd6000, 32'd1, FL_FORCED);
        send_directed(64'd6100, 32'd10, FL_REF);
        send_directed(64'd6200, 32'd10, FL_REF);
        send_directed(64'd6300, 32'd10, FL_REF | FL_FORCED);
        send_directed(64'd0, 32'd20, FL_INFER | FL_FORCED);
        send_directed(64'd7500, 32'd10, FL_REF);
        send_directed(64'd7600, 32'd0, FL_NONE);
        send_directed(64'd9000, 32'd2, FL_REF | FL_INFER);

        // zero window length: samples leave the window untouched
        load_settings(32'd0, 16'd3300, 16'd120, 16'd8, 16'd60, 16'd25, 16'd40, 32'd1500);
        send_random(4);

        for (int m = 0; m < 4; m++) begin
            if (m == 1)
                load_settings(32'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0);
            else
                load_settings($urandom_range(200, 5000), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 3000));
            case (m)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 45; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase
            send_random(160);
        end

        // largest settings with huge spans, so the energy products wrap
        send_idle_pct = 0;
        stall_pct = 0;
        load_settings(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 32'hFFFF_FFFF);
        rnd = {$urandom, $urandom};
        send_directed(clock_us + 64'd1, 32'hFFFF_FFFF, FL_REF);
        send_directed({2'b01, rnd[61:0]}, 32'd77, FL_REF);
        send_directed(64'hFFFF_FFFE_0000_0000, 32'd0, FL_INFER);
        send_directed({64{1'b1}}, 32'hFFFF_FFFF, FL_REF | FL_INFER | FL_FORCED);
        settle();

        $display("sent %0d frame samples, checked %0d window reports over %0d register settings",
                 tracker.samples_noted, tracker.reports_checked, settings_used);
        $display("field mismatches: %0d", tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0)
            $display("[windowed_energy_accumulator] OK");
        else
            $display("[windowed_energy_accumulator] ERROR");
        $finish;
    end
endmodule
